// ----- rtl/core/tmr_pkg.sv -----
// ============================================================================
// tmr_pkg
// Shared types and constants of the tile map entry pixel renderer.
// ============================================================================
package tmr_pkg;

    localparam int TILE_COUNT_DEF      = 1024;
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int TILE_BYTES          = 32;
    localparam int QUEUE_DEPTH         = 4;
    localparam int TILE_PIXELS         = 64;

    localparam logic [1:0] OP_TILE_WRITE = 2'd0;
    localparam logic [1:0] OP_PAL_WRITE  = 2'd1;
    localparam logic [1:0] OP_DRAW       = 2'd2;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    typedef enum logic [2:0] {
        CMD_TILE = 3'b001,
        CMD_PAL  = 3'b010,
        CMD_DRAW = 3'b100
    } cmd_kind_t;

    typedef struct packed {
        logic [9:0] tile;
        logic       hflip;
        logic       vflip;
        logic [3:0] bank;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic       front;
    } draw_ctx_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [14:0] address;
        logic [14:0] write_data;
        draw_ctx_t   draw;
    } cmd_t;

    typedef struct packed {
        logic        front;
        logic [14:0] color;
        logic [10:0] screen_y;
        logic [10:0] screen_x;
    } pixel_t;

endpackage

// ----- rtl/core/tile_map_entry_pixel_renderer.sv -----
// ============================================================================
// tile_map_entry_pixel_renderer
// Renders one 4-bit-per-pixel tile map entry into a stream of opaque pixels.
// ============================================================================
// Load beats fill the tile store (one byte each) and the palette (one BGR555
// word each); they cause no output. A draw beat walks its 8x8 tile at one
// pixel per cycle while the pipeline is not stalled, and the beat of the
// final pixel leaves after the read stages and the release of the final
// pixel. It emits one beat per opaque pixel with m_tlast on the final one.
// The release of a final pixel holds the next walk until the output register
// is free. A draw that follows another is taken once the previous walk has
// ended. A load beat that follows a draw waits until the pixel pipeline has
// drained.
// A four-entry queue lets input beats be taken while a tile is being walked,
// and the output register lets the walk continue while a pixel waits.
// Draws with tile index zero or at or beyond the tile count produce no beats.
module tile_map_entry_pixel_renderer #(
    parameter int TILE_COUNT      = tmr_pkg::TILE_COUNT_DEF,
    parameter int PALETTE_ENTRIES = tmr_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // address, write_data, map_entry, cell_x, cell_y, front_layer
    input  logic [tmr_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // screen_x, screen_y, pixel_color, front_mark
    output logic [tmr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import tmr_pkg::*;

    logic   f_valid, f_ready;
    cmd_t   f_cmd;
    logic   q_valid, q_ready;
    cmd_t   q_cmd;
    pixel_t pix;

    tmr_front #(
        .TILE_COUNT      (TILE_COUNT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    tmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    tmr_back #(
        .TILE_COUNT      (TILE_COUNT),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (pix),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, pix.front, pix.color, pix.screen_y, pix.screen_x};

endmodule

// ----- rtl/core/tmr_front.sv -----
// ============================================================================
// tmr_front
// Input stage: accepts beats, drops those that do nothing, and hands the
// remaining ones on as decoded commands.
// ============================================================================
module tmr_front #(
    parameter int TILE_COUNT      = tmr_pkg::TILE_COUNT_DEF,
    parameter int PALETTE_ENTRIES = tmr_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tmr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [1:0]                         s_tuser,
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output tmr_pkg::cmd_t                      cmd
);
    import tmr_pkg::*;

    logic        valid_reg, valid_next;
    cmd_t        cmd_reg, cmd_next;
    logic        keep;
    logic [14:0] in_addr;
    logic [15:0] in_entry;

    assign in_addr  = s_tdata[14:0];
    assign in_entry = s_tdata[45:30];

    always_comb begin
        cmd_next                 = cmd_reg;
        cmd_next.address         = in_addr;
        cmd_next.write_data      = s_tdata[29:15];
        cmd_next.draw.tile       = in_entry[9:0];
        cmd_next.draw.hflip      = in_entry[10];
        cmd_next.draw.vflip      = in_entry[11];
        cmd_next.draw.bank       = in_entry[15:12];
        cmd_next.draw.cell_x     = s_tdata[53:46];
        cmd_next.draw.cell_y     = s_tdata[61:54];
        cmd_next.draw.front      = s_tdata[62];
        keep                     = 1'b0;
        case (s_tuser)
            OP_TILE_WRITE: begin
                cmd_next.kind = CMD_TILE;
                keep = {17'd0, in_addr} < 32'(TILE_COUNT * TILE_BYTES);
            end
            OP_PAL_WRITE: begin
                cmd_next.kind = CMD_PAL;
                keep = {24'd0, in_addr[7:0]} < 32'(PALETTE_ENTRIES);
            end
            OP_DRAW: begin
                cmd_next.kind = CMD_DRAW;
                keep = (in_entry[9:0] != 10'd0) &&
                       ({22'd0, in_entry[9:0]} < 32'(TILE_COUNT));
            end
            default: begin
                cmd_next.kind = CMD_DRAW;
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = !valid_reg || cmd_ready;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && cmd_ready) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ----- rtl/core/tmr_queue.sv -----
// ============================================================================
// tmr_queue
// Short command queue that decouples the input stage from the renderer.
// ============================================================================
module tmr_queue #(
    parameter int DEPTH = tmr_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  tmr_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output tmr_pkg::cmd_t out_cmd
);
    import tmr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/core/tmr_back.sv -----
// ============================================================================
// tmr_back
// Renderer: owns the tile and palette stores, walks the 64 pixels of a
// drawn tile through a three-stage read pipeline, and holds back one
// opaque pixel so that the final one can be marked.
// ============================================================================
module tmr_back #(
    parameter int TILE_COUNT      = tmr_pkg::TILE_COUNT_DEF,
    parameter int PALETTE_ENTRIES = tmr_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  tmr_pkg::cmd_t   cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output tmr_pkg::pixel_t out_pix,
    output logic            out_last
);
    import tmr_pkg::*;

    localparam int TILE_DEPTH = TILE_COUNT * TILE_BYTES;
    localparam int TILE_AW    = $clog2(TILE_DEPTH);
    localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);

    logic [7:0]  tile_mem_reg [TILE_DEPTH];
    logic [14:0] pal_mem_reg  [PALETTE_ENTRIES];

    logic       a_active_reg;
    logic [5:0] a_idx_reg;
    draw_ctx_t  a_ctx_reg;

    logic       b_valid_reg;
    logic [5:0] b_idx_reg;
    draw_ctx_t  b_ctx_reg;
    logic [7:0] tile_q_reg;

    logic       c_valid_reg;
    logic [5:0] c_idx_reg;
    draw_ctx_t  c_ctx_reg;
    logic       c_opaque_reg;
    logic       c_oob_reg;
    logic [14:0] pal_q_reg;

    logic       pend_valid_reg;
    logic       pend_final_reg;
    pixel_t     pend_pix_reg;

    logic       out_valid_reg;
    logic       out_last_reg;
    pixel_t     out_pix_reg;

    logic       cmd_fire, load_ok, out_free, stall, adv;
    logic [14:0] tile_rd_full;
    logic [3:0] b_nib;
    logic [7:0] b_pidx;
    logic [2:0] c_px, c_py;
    pixel_t     c_pix;

    assign load_ok   = !a_active_reg && !b_valid_reg && !c_valid_reg;
    assign cmd_ready = (cmd.kind == CMD_DRAW) ? !a_active_reg : load_ok;
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign out_free = !out_valid_reg || out_ready;
    assign stall    = pend_final_reg ||
                      (c_valid_reg && c_opaque_reg && pend_valid_reg && !out_free);
    assign adv      = !stall;

    assign tile_rd_full = {a_ctx_reg.tile, a_idx_reg[5:3], a_idx_reg[2:1]};
    assign b_nib        = b_idx_reg[0] ? tile_q_reg[7:4] : tile_q_reg[3:0];
    assign b_pidx       = {b_ctx_reg.bank, b_nib};

    always_comb begin
        c_px           = c_ctx_reg.hflip ? ~c_idx_reg[2:0] : c_idx_reg[2:0];
        c_py           = c_ctx_reg.vflip ? ~c_idx_reg[5:3] : c_idx_reg[5:3];
        c_pix.screen_x = {c_ctx_reg.cell_x, c_px};
        c_pix.screen_y = {c_ctx_reg.cell_y, c_py};
        c_pix.color    = c_oob_reg ? 15'd0 : pal_q_reg;
        c_pix.front    = c_ctx_reg.front;
    end

    always_ff @(posedge aclk) begin
        if (cmd_fire && (cmd.kind == CMD_TILE)) begin
            tile_mem_reg[cmd.address[TILE_AW-1:0]] <= cmd.write_data[7:0];
        end
        if (cmd_fire && (cmd.kind == CMD_PAL)) begin
            pal_mem_reg[cmd.address[PAL_AW-1:0]] <= cmd.write_data;
        end
        if (adv) begin
            tile_q_reg <= tile_mem_reg[tile_rd_full[TILE_AW-1:0]];
            pal_q_reg  <= pal_mem_reg[b_pidx[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_fire && (cmd.kind == CMD_DRAW)) begin
            a_ctx_reg <= cmd.draw;
        end
        if (adv) begin
            b_idx_reg    <= a_idx_reg;
            b_ctx_reg    <= a_ctx_reg;
            c_idx_reg    <= b_idx_reg;
            c_ctx_reg    <= b_ctx_reg;
            c_opaque_reg <= b_nib != 4'd0;
            c_oob_reg    <= {24'd0, b_pidx} >= 32'(PALETTE_ENTRIES);
        end
        if (adv && c_valid_reg && c_opaque_reg) begin
            pend_pix_reg <= c_pix;
        end
        if (pend_final_reg && out_free) begin
            out_pix_reg  <= pend_pix_reg;
            out_last_reg <= 1'b1;
        end else if (adv && c_valid_reg && c_opaque_reg && pend_valid_reg) begin
            out_pix_reg  <= pend_pix_reg;
            out_last_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_active_reg   <= 1'b0;
            a_idx_reg      <= '0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd_fire && (cmd.kind == CMD_DRAW)) begin
                a_active_reg <= 1'b1;
                a_idx_reg    <= '0;
            end else if (adv && a_active_reg) begin
                a_idx_reg <= a_idx_reg + 1'b1;
                if (a_idx_reg == 6'(TILE_PIXELS - 1)) begin
                    a_active_reg <= 1'b0;
                end
            end
            if (adv) begin
                b_valid_reg <= a_active_reg;
                c_valid_reg <= b_valid_reg;
            end

            if (pend_final_reg && out_free) begin
                pend_valid_reg <= 1'b0;
                pend_final_reg <= 1'b0;
            end else if (adv && c_valid_reg) begin
                if (c_opaque_reg) begin
                    pend_valid_reg <= 1'b1;
                    pend_final_reg <= c_idx_reg == 6'(TILE_PIXELS - 1);
                end else if ((c_idx_reg == 6'(TILE_PIXELS - 1)) && pend_valid_reg) begin
                    pend_final_reg <= 1'b1;
                end
            end

            if ((pend_final_reg && out_free) ||
                (adv && c_valid_reg && c_opaque_reg && pend_valid_reg)) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- rtl/core/tmr_checker.sv -----
// ============================================================================
// tmr_checker
// Port-level checks of the tile map entry pixel renderer output stream.
// ============================================================================
module tmr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // The padding bits above the front mark are never set.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:38] == 2'b00))
        else $error("m_tdata padding bits set");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled beat changed");

endmodule

bind tile_map_entry_pixel_renderer tmr_checker u_tmr_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map entry pixel renderer testbench
// Loads the palette and a set of tiles, then draws map entries and checks
// every pixel beat against a predictor that walks the same tile data.
// ----------------------------------------------------------------------------
module tb;

    import tmr_pkg::*;

    localparam int          TILE_COUNT       = TILE_COUNT_DEF;
    localparam int          PALETTE_ENTRIES  = PALETTE_ENTRIES_DEF;
    localparam int          TILE_STORE_BYTES = 32768;
    localparam logic [1:0]  OP_UNUSED        = 2'd3;
    localparam int          FILL_MIXED       = 0;
    localparam int          FILL_CLEAR       = 1;
    localparam int          FILL_SOLID       = 2;
    localparam int          HOLD_OFF_CYCLES  = 400;

    typedef struct packed {
        logic   last;
        pixel_t px;
    } drawn_pixel_t;

    class pixel_predictor;
        logic [7:0]   tile_bytes [TILE_STORE_BYTES];
        logic [14:0]  palette_words [256];
        drawn_pixel_t pending_pixels [$];
        int           mismatches;

        function new();
            foreach (tile_bytes[i]) tile_bytes[i] = 8'h00;
            foreach (palette_words[i]) palette_words[i] = 15'h0000;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void note_beat(logic [1:0] op, logic [63:0] tdata);
            logic [14:0]  addr;
            logic [14:0]  wdata;
            logic [15:0]  entry;
            logic [7:0]   cx;
            logic [7:0]   cy;
            logic         front;
            logic [7:0]   v;
            logic [3:0]   nib;
            int           tile;
            int           bank;
            int           idx;
            int           px;
            int           py;
            int           count;
            drawn_pixel_t p;
            addr  = tdata[14:0];
            wdata = tdata[29:15];
            entry = tdata[45:30];
            cx    = tdata[53:46];
            cy    = tdata[61:54];
            front = tdata[62];
            count = 0;
            case (op)
                OP_TILE_WRITE: begin
                    if (int'(addr) < TILE_COUNT * TILE_BYTES)
                        tile_bytes[addr] = wdata[7:0];
                end
                OP_PAL_WRITE: begin
                    if (int'(addr[7:0]) < PALETTE_ENTRIES)
                        palette_words[addr[7:0]] = wdata;
                end
                OP_DRAW: begin
                    tile = int'(entry[9:0]);
                    bank = int'(entry[15:12]);
                    if (tile != 0 && tile < TILE_COUNT) begin
                        for (int y = 0; y < 8; y++) begin
                            for (int x = 0; x < 8; x++) begin
                                v   = tile_bytes[15'(tile * TILE_BYTES + y * 4 + x / 2)];
                                nib = (x % 2 == 1) ? v[7:4] : v[3:0];
                                if (nib != 4'd0) begin
                                    px  = entry[10] ? 7 - x : x;
                                    py  = entry[11] ? 7 - y : y;
                                    idx = bank * 16 + int'(nib);
                                    p.last        = 1'b0;
                                    p.px.front    = front;
                                    p.px.color    = (idx < PALETTE_ENTRIES) ?
                                                    palette_words[idx] : 15'h0000;
                                    p.px.screen_x = 11'(int'(cx) * 8 + px);
                                    p.px.screen_y = 11'(int'(cy) * 8 + py);
                                    pending_pixels.push_back(p);
                                    count++;
                                end
                            end
                        end
                        if (count > 0)
                            pending_pixels[pending_pixels.size() - 1].last = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("%0t MISMATCH %s", $time, what);
            mismatches++;
        endtask

        task check_pixel(logic [39:0] tdata, logic tlast);
            drawn_pixel_t want;
            pixel_t       got;
            if (pending_pixels.size() == 0) begin
                report($sformatf("pixel beat with nothing expected: tdata %h last %b",
                                 tdata, tlast));
                return;
            end
            want = pending_pixels.pop_front();
            got  = tdata[37:0];
            if (got.screen_x !== want.px.screen_x)
                report($sformatf("screen_x got %0d want %0d", got.screen_x,
                                 want.px.screen_x));
            if (got.screen_y !== want.px.screen_y)
                report($sformatf("screen_y got %0d want %0d", got.screen_y,
                                 want.px.screen_y));
            if (got.color !== want.px.color)
                report($sformatf("pixel_color got %h want %h", got.color, want.px.color));
            if (got.front !== want.px.front)
                report($sformatf("front_mark got %b want %b", got.front, want.px.front));
            if (tlast !== want.last)
                report($sformatf("last_pixel got %b want %b at (%0d,%0d)", tlast,
                                 want.last, want.px.screen_x, want.px.screen_y));
        endtask
    endclass

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    pixel_predictor pred = new();

    bit byte_loaded [TILE_STORE_BYTES];
    bit tile_ready [TILE_COUNT];
    int ready_tiles [$];
    int burst_left;
    bit hold_off_req;

    tile_map_entry_pixel_renderer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] pack_beat(logic [14:0] addr, logic [14:0] wdata,
                                              logic [15:0] entry, logic [7:0] cx,
                                              logic [7:0] cy, logic front);
        return {1'b0, front, cy, cx, entry, wdata, addr};
    endfunction

    function automatic logic [3:0] pick_nibble(int style);
        if (style == FILL_CLEAR)
            return 4'd0;
        if (style == FILL_MIXED && $urandom_range(0, 2) == 0)
            return 4'd0;
        return 4'($urandom_range(1, 15));
    endfunction

    // Picks the lowest or the highest palette bank, the two that are loaded first.
    function automatic int pick_bank();
        return ($urandom_range(0, 1) == 0) ? 0 : 15;
    endfunction

    task automatic send_beat(logic [1:0] op, logic [63:0] tdata, bit paced = 1'b1);
        int gap;
        if (paced && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
                                                       $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        s_tuser  <= op;
        s_tdata  <= tdata;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pred.note_beat(op, tdata);
        @(negedge aclk);
    endtask

    task automatic write_tile_byte(int addr, logic [7:0] value);
        int  t;
        bit  full;
        send_beat(OP_TILE_WRITE, pack_beat(15'(addr), {7'($urandom), value},
                  16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)));
        byte_loaded[addr] = 1'b1;
        t = addr / TILE_BYTES;
        if (!tile_ready[t] && t != 0) begin
            full = 1'b1;
            for (int b = 0; b < TILE_BYTES; b++)
                full &= byte_loaded[t * TILE_BYTES + b];
            if (full) begin
                tile_ready[t] = 1'b1;
                ready_tiles.push_back(t);
            end
        end
    endtask

    task automatic load_tile(int t, int style);
        for (int b = 0; b < TILE_BYTES; b++)
            write_tile_byte(t * TILE_BYTES + b, {pick_nibble(style), pick_nibble(style)});
    endtask

    task automatic write_palette(logic [14:0] addr, logic [14:0] color);
        send_beat(OP_PAL_WRITE, pack_beat(addr, color, 16'($urandom), 8'($urandom),
                  8'($urandom), 1'($urandom)));
    endtask

    task automatic send_draw(int tile, bit hf, bit vf, int bank, int cx, int cy,
                             bit front, bit paced = 1'b1);
        send_beat(OP_DRAW, pack_beat(15'($urandom), 15'($urandom),
                  {4'(bank), vf, hf, 10'(tile)}, 8'(cx), 8'(cy), front), paced);
    endtask

    task automatic draw_random_ready(bit paced);
        send_draw(ready_tiles[$urandom_range(0, ready_tiles.size() - 1)],
                  1'($urandom), 1'($urandom), pick_bank(),
                  $urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom), paced);
    endtask

    initial begin
        int mode;
        int span;
        m_tready = 1'b0;
        do @(negedge aclk); while (!aresetn);
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 80);
            repeat (span) begin
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    m_tready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            pred.check_pixel(m_tdata, m_tlast);
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int r;
        int n;
        int t;
        int counted;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_TILE_WRITE;
        burst_left   = 0;
        hold_off_req = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Banks zero and fifteen are loaded, and every draw uses one of them.
        for (int i = 0; i < 16; i++) begin
            write_palette({7'($urandom), 8'(i)}, 15'($urandom));
            write_palette({7'($urandom), 8'(240 + i)}, 15'($urandom));
        end
        load_tile(1, FILL_MIXED);
        load_tile(2, FILL_CLEAR);
        load_tile(TILE_COUNT - 1, FILL_SOLID);

        send_draw(1, 1'b0, 1'b0, 0, 0, 0, 1'b0);
        send_draw(1, 1'b1, 1'b0, 15, 255, 255, 1'b1);
        send_draw(1, 1'b0, 1'b1, 0, 17, 200, 1'b0);
        send_draw(1, 1'b1, 1'b1, 15, 255, 0, 1'b1);
        send_draw(2, 1'b1, 1'b1, 15, 255, 255, 1'b1);
        send_draw(TILE_COUNT - 1, 1'b1, 1'b1, 15, 255, 255, 1'b1);
        send_beat(OP_DRAW, pack_beat(15'h7FFF, 15'h7FFF, 16'hFC00, 8'hFF, 8'hFF, 1'b1));
        send_beat(OP_UNUSED, {64{1'b1}});
        send_beat(OP_UNUSED, '0);
        write_palette(15'h7FFF, 15'h7FFF);
        write_palette(15'h7F00, 15'h0000);
        write_tile_byte(TILE_STORE_BYTES - 1, 8'h00);
        write_tile_byte(TILE_STORE_BYTES - 2, 8'hFF);
        send_draw(TILE_COUNT - 1, 1'b0, 1'b0, 15, 128, 64, 1'b0);
        write_tile_byte(TILE_BYTES, 8'hFF);
        send_draw(1, 1'b0, 1'b0, 0, 1, 1, 1'b1);

        // The receiver holds off while draws are offered back to back, then the
        // sender waits for the block to drain completely.
        hold_off_req = 1'b1;
        repeat (12) draw_random_ready(1'b0);
        s_tvalid <= 1'b0;
        while (pred.pending() != 0) @(negedge aclk);

        counted = 0;
        while (counted < 20) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                draw_random_ready(1'b1);
                counted++;
            end else if (r < 60) begin
                n = $urandom_range(1, 4);
                t = ready_tiles[$urandom_range(0, ready_tiles.size() - 1)];
                repeat (n)
                    write_tile_byte(t * TILE_BYTES + $urandom_range(0, TILE_BYTES - 1),
                                    {pick_nibble(FILL_MIXED), pick_nibble(FILL_MIXED)});
                counted += n;
            end else if (r < 70) begin
                write_palette(15'($urandom), 15'($urandom));
                counted++;
            end else if (r < 76) begin
                t = $urandom_range(1, TILE_COUNT - 1);
                n = $urandom_range(0, 5);
                load_tile(t, (n == 0) ? FILL_CLEAR : (n == 1) ? FILL_SOLID : FILL_MIXED);
                send_draw(t, 1'($urandom), 1'($urandom), pick_bank(),
                          $urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom));
                counted += TILE_BYTES + 1;
            end else if (r < 82) begin
                write_tile_byte($urandom_range(0, TILE_STORE_BYTES - 1), 8'($urandom));
                counted++;
            end else if (r < 91) begin
                send_beat(OP_DRAW, pack_beat(15'($urandom), 15'($urandom),
                          {6'($urandom), 10'd0}, 8'($urandom), 8'($urandom), 1'($urandom)));
            end else begin
                send_beat(OP_UNUSED, {1'b0, 63'({$urandom, $urandom})});
            end
        end

        s_tvalid <= 1'b0;
        while (pred.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (pred.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
